### sv/utf8_string_validator_core_assert.svh
// Assertion macros shared by the validator RTL.
// Every check is sampled on the rising clock edge.
// Every check is switched off while reset is low.
`ifndef UTF8_STRING_VALIDATOR_CORE_ASSERT_SVH
`define UTF8_STRING_VALIDATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define U8SV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define U8SV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/u8sv_pkg.sv
// ----------------------------------------------------------------------------
// u8sv_pkg
// Shared types for the UTF-8 string validator: status and kind codes,
// register indexes and the per-string decode state.
// ----------------------------------------------------------------------------
package u8sv_pkg;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_EMPTY     = 4'd1,
    ST_TOO_LONG  = 4'd2,
    ST_MALFORMED = 4'd3,
    ST_CONTROL   = 4'd4,
    ST_NON_ASCII = 4'd5,
    ST_IDENT     = 4'd6,
    ST_TOKEN     = 4'd7,
    ST_STRUCT    = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    KIND_ARG     = 3'd0,
    KIND_CONFIG  = 3'd1,
    KIND_PATH    = 3'd2,
    KIND_URL     = 3'd3,
    KIND_DISPLAY = 3'd4,
    KIND_IDENT   = 3'd5,
    KIND_TOKEN   = 3'd6,
    KIND_STRUCT  = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    CFG_KIND        = 2'd0,
    CFG_MAX_LEN     = 2'd1,
    CFG_ALLOW_EMPTY = 2'd2
  } cfg_index_e;

  localparam logic [15:0] MaxLenReset = 16'd4096;

  // Running decode state of the current string.
  typedef struct packed {
    logic [1:0]  pending;
    logic [20:0] partial;
    logic [1:0]  seq_class;
    status_e     first_err;
    status_e     class_err;
    logic        at_start;
  } dec_state_t;

  localparam dec_state_t DecStateReset = '{
    pending:   2'd0,
    partial:   21'd0,
    seq_class: 2'd0,
    first_err: ST_OK,
    class_err: ST_OK,
    at_start:  1'b1
  };

endpackage

### sv/utf8_string_validator_core.sv
// ----------------------------------------------------------------------------
// utf8_string_validator_core
// Streaming strict UTF-8 string validator: one byte per word in, one status
// word out on the string's last byte or on an empty-string marker.
//
//   channel   direction  handshake              payload
//   cfg       in         cfg_we_i               cfg_index_i, cfg_data_i
//   in        in         in_valid_i/in_stall_o  data_byte_i, last_byte_i,
//                                               empty_marker_i
//   out       out        out_valid_o/out_stall_i status_o, length_o
//
// One word is taken per cycle while in_stall_o is low. The input register
// feeds the decode step, which writes the string state and the output
// register in the same cycle.
// A non-final byte moves on even while the output is stalled; a final byte
// or an empty marker waits in the input register until the output frees.
// Reset clears the configuration to its defaults and starts a new string.
// ----------------------------------------------------------------------------
`include "utf8_string_validator_core_assert.svh"

module utf8_string_validator_core #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [15:0]                cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 data_byte_i,
  input  logic                       last_byte_i,
  input  logic                       empty_marker_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [3:0]                 status_o,
  output logic [15:0]                length_o
);

  localparam int CmpBits = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

  // Configuration
  u8sv_pkg::kind_e kind_q;
  logic [15:0]     max_len_q;
  logic            allow_empty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q        <= u8sv_pkg::KIND_ARG;
      max_len_q     <= u8sv_pkg::MaxLenReset;
      allow_empty_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        u8sv_pkg::CFG_KIND:        kind_q        <= u8sv_pkg::kind_e'(cfg_data_i[2:0]);
        u8sv_pkg::CFG_MAX_LEN:     max_len_q     <= cfg_data_i;
        u8sv_pkg::CFG_ALLOW_EMPTY: allow_empty_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       s1_empty_q;
  logic       s1_yields;
  logic       s1_fire;
  logic       out_free;
  logic       in_acc;

  assign s1_yields  = s1_last_q || s1_empty_q;
  assign out_free   = !out_valid_o || !out_stall_i;
  assign s1_fire    = s1_valid_q && (!s1_yields || out_free);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q  <= data_byte_i;
      s1_last_q  <= last_byte_i;
      s1_empty_q <= empty_marker_i;
    end
  end

  // String state
  u8sv_pkg::dec_state_t st_q, st_d, st_step;
  logic [LENGTH_BITS-1:0] count_q, count_d, count_inc;

  u8sv_step u_step (
    .st_i   (st_q),
    .kind_i (kind_q),
    .byte_i (s1_byte_q),
    .st_o   (st_step)
  );

  // Saturate the byte count.
  assign count_inc = (count_q == {LENGTH_BITS{1'b1}}) ? count_q :
                     count_q + LENGTH_BITS'(1);

  logic [CmpBits-1:0] count_ext;
  logic [CmpBits-1:0] max_ext;
  u8sv_pkg::status_e  fin_status;

  assign count_ext = CmpBits'(count_inc);
  assign max_ext   = CmpBits'(max_len_q);

  always_comb begin
    priority if (count_ext > max_ext) begin
      fin_status = u8sv_pkg::ST_TOO_LONG;
    end else if (st_step.first_err != u8sv_pkg::ST_OK) begin
      fin_status = st_step.first_err;
    end else if (st_step.pending != 2'd0) begin
      fin_status = u8sv_pkg::ST_MALFORMED;
    end else begin
      fin_status = st_step.class_err;
    end
  end

  always_comb begin
    st_d    = st_q;
    count_d = count_q;
    if (s1_fire) begin
      if (s1_yields) begin
        st_d    = u8sv_pkg::DecStateReset;
        count_d = '0;
      end else begin
        st_d    = st_step;
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= u8sv_pkg::DecStateReset;
      count_q <= '0;
    end else begin
      st_q    <= st_d;
      count_q <= count_d;
    end
  end

  // Output register
  logic              out_valid_q, out_valid_d;
  u8sv_pkg::status_e status_q;
  logic [15:0]       length_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire && s1_yields) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_yields) begin
      if (s1_empty_q) begin
        status_q <= allow_empty_q ? u8sv_pkg::ST_OK : u8sv_pkg::ST_EMPTY;
        length_q <= 16'd0;
      end else begin
        status_q <= fin_status;
        length_q <= count_ext[15:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign length_o    = length_q;

  // Checks
  `U8SV_ASSERT_IMP(a_no_overwrite, out_valid_q && out_stall_i, !(s1_fire && s1_yields), "result overwritten while stalled")
  `U8SV_ASSERT_NXT(a_clear_after_result, s1_fire && s1_yields, count_q == '0 && st_q.at_start, "string state not cleared after result")
  `U8SV_ASSERT_NXT(a_count_monotonic, !(s1_fire && s1_yields), count_q >= $past(count_q), "byte count dropped within a string")
  `U8SV_ASSERT_IMP(a_pending_has_class, st_q.pending != 2'd0, st_q.seq_class != 2'd0, "pending continuations without sequence class")

endmodule

### sv/u8sv_step.sv
// ----------------------------------------------------------------------------
// u8sv_step
// One-byte update of the decode state: strict UTF-8 decode, codepoint
// safety checks and the ASCII character class checks of each kind.
// ----------------------------------------------------------------------------
module u8sv_step (
  input  u8sv_pkg::dec_state_t st_i,
  input  u8sv_pkg::kind_e      kind_i,
  input  logic [7:0]           byte_i,
  output u8sv_pkg::dec_state_t st_o
);

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  // tab, alnum, or one of _ . , : = + \ - / @ % { } [ ] ( ) space
  function automatic logic is_struct_char(input logic [7:0] c);
    return c == 8'h09 || is_alnum(c) ||
           c == 8'h5F || c == 8'h2E || c == 8'h2C || c == 8'h3A ||
           c == 8'h3D || c == 8'h2B || c == 8'h5C || c == 8'h2D ||
           c == 8'h2F || c == 8'h40 || c == 8'h25 || c == 8'h7B ||
           c == 8'h7D || c == 8'h5B || c == 8'h5D || c == 8'h28 ||
           c == 8'h29 || c == 8'h20;
  endfunction

  function automatic logic is_unsafe_cp(input logic [20:0] cp);
    return cp == 21'h000AD || cp == 21'h0061C ||
           (cp >= 21'h0200B && cp <= 21'h0200F) ||
           cp == 21'h02028 || cp == 21'h02029 ||
           (cp >= 21'h0202A && cp <= 21'h0202E) ||
           (cp >= 21'h02060 && cp <= 21'h0206F) ||
           cp == 21'h03164 || cp == 21'h0FEFF ||
           (cp >= 21'h0FDD0 && cp <= 21'h0FDEF) ||
           cp[15:0] == 16'hFFFE || cp[15:0] == 16'hFFFF;
  endfunction

  function automatic u8sv_pkg::status_e check_cp(input logic [20:0] cp,
                                                 input u8sv_pkg::kind_e kind);
    logic tab_ok;
    logic ascii_only;
    tab_ok     = (kind == u8sv_pkg::KIND_CONFIG || kind == u8sv_pkg::KIND_STRUCT) &&
                 cp == 21'h00009;
    ascii_only = kind == u8sv_pkg::KIND_IDENT || kind == u8sv_pkg::KIND_TOKEN ||
                 kind == u8sv_pkg::KIND_STRUCT;
    if ((!tab_ok && cp < 21'h00020) || cp == 21'h0007F ||
        (cp >= 21'h00080 && cp < 21'h000A0) || is_unsafe_cp(cp)) begin
      return u8sv_pkg::ST_CONTROL;
    end
    if (ascii_only && cp > 21'h0007F) begin
      return u8sv_pkg::ST_NON_ASCII;
    end
    return u8sv_pkg::ST_OK;
  endfunction

  u8sv_pkg::dec_state_t nxt;
  u8sv_pkg::status_e    err;
  logic [20:0]          cp;
  logic [20:0]          cp_min;

  assign cp = {st_i.partial[14:0], byte_i[5:0]};

  always_comb begin
    unique case (st_i.seq_class)
      2'd1:    cp_min = 21'h00080;
      2'd2:    cp_min = 21'h00800;
      default: cp_min = 21'h10000;
    endcase
  end

  always_comb begin
    nxt = st_i;
    err = u8sv_pkg::ST_OK;

    // Decode stops at the first error of the string.
    if (st_i.first_err == u8sv_pkg::ST_OK) begin
      if (st_i.pending == 2'd0) begin
        priority if (byte_i < 8'h80) begin
          err = check_cp({13'd0, byte_i}, kind_i);
        end else if (byte_i >= 8'hC2 && byte_i <= 8'hDF) begin
          nxt.pending   = 2'd1;
          nxt.partial   = {16'd0, byte_i[4:0]};
          nxt.seq_class = 2'd1;
        end else if (byte_i >= 8'hE0 && byte_i <= 8'hEF) begin
          nxt.pending   = 2'd2;
          nxt.partial   = {17'd0, byte_i[3:0]};
          nxt.seq_class = 2'd2;
        end else if (byte_i >= 8'hF0 && byte_i <= 8'hF4) begin
          nxt.pending   = 2'd3;
          nxt.partial   = {18'd0, byte_i[2:0]};
          nxt.seq_class = 2'd3;
        end else begin
          err = u8sv_pkg::ST_MALFORMED;
        end
      end else if (byte_i[7:6] != 2'b10) begin
        err = u8sv_pkg::ST_MALFORMED;
      end else begin
        nxt.partial = cp;
        nxt.pending = st_i.pending - 2'd1;
        // Last continuation: range, overlong and surrogate checks, then codepoint checks.
        if (st_i.pending == 2'd1) begin
          if (cp < cp_min || cp > 21'h10FFFF ||
              (cp >= 21'h0D800 && cp <= 21'h0DFFF)) begin
            err = u8sv_pkg::ST_MALFORMED;
          end else begin
            err = check_cp(cp, kind_i);
          end
        end
      end
      if (err != u8sv_pkg::ST_OK) begin
        nxt.first_err = err;
      end
    end

    // Class checks run on raw bytes; keep the first failure.
    if (st_i.class_err == u8sv_pkg::ST_OK) begin
      unique case (kind_i)
        u8sv_pkg::KIND_IDENT: begin
          if (!((st_i.at_start ? is_alpha(byte_i) : is_alnum(byte_i)) ||
                byte_i == 8'h5F)) begin
            nxt.class_err = u8sv_pkg::ST_IDENT;
          end
        end
        u8sv_pkg::KIND_TOKEN: begin
          if (!(is_alnum(byte_i) || byte_i == 8'h5F || byte_i == 8'h2D ||
                byte_i == 8'h2E || byte_i == 8'h2B)) begin
            nxt.class_err = u8sv_pkg::ST_TOKEN;
          end
        end
        u8sv_pkg::KIND_STRUCT: begin
          if (!is_struct_char(byte_i)) begin
            nxt.class_err = u8sv_pkg::ST_STRUCT;
          end
        end
        default: begin
        end
      endcase
    end

    nxt.at_start = 1'b0;
  end

  assign st_o = nxt;

endmodule

### test/tb_utf8_string_validator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_string_validator_core
// Self-checking bench for the streaming UTF-8 string validator. A directed
// table covers the decode corner cases. Random strings follow, built mostly
// from legal characters for the active kind plus encoded codepoints, overlong
// forms, surrogates, unsafe codepoints and raw noise. They run through eight
// register settings. Each status word is checked against its directed row's
// typed expectation if any, else against an in-bench model of the decoder.
// ----------------------------------------------------------------------------
module tb_utf8_string_validator_core;

  localparam int LimitCycles  = 1_000_000;
  localparam int SettleCycles = 8;
  localparam int HoldCycles   = 400;
  localparam int PhaseWords   = 130;
  // index past the register list; the block drops it
  localparam logic [1:0] CfgSpare = 2'd3;

  typedef struct packed {
    u8sv_pkg::status_e status;
    logic [15:0]       length;
  } result_word_t;

  typedef struct packed {
    logic [7:0]        data;
    logic              last;
    logic              empty;
    logic              typed;
    u8sv_pkg::status_e status;
    logic [15:0]       length;
  } stim_row_t;

  localparam stim_row_t DirectedRows [26] = '{
    '{8'hFF, 1'b1, 1'b1, 1'b1, u8sv_pkg::ST_EMPTY,     16'd0},
    '{8'h41, 1'b1, 1'b0, 1'b1, u8sv_pkg::ST_OK,        16'd1},
    '{8'h00, 1'b1, 1'b0, 1'b1, u8sv_pkg::ST_CONTROL,   16'd1},
    '{8'hFF, 1'b0, 1'b0, 1'b0, u8sv_pkg::ST_OK,        16'd0},
    '{8'h41, 1'b1, 1'b0, 1'b1, u8sv_pkg::ST_MALFORMED, 16'd2},
    '{8'h7F, 1'b1, 1'b0, 1'b1, u8sv_pkg::ST_CONTROL,   16'd1},
    '{8'hE0, 1'b0, 1'b0, 1'b0, u8sv_pkg::ST_OK,        16'd0},
    '{8'h80, 1'b0, 1'b0, 1'b0, u8sv_pkg::ST_OK,        16'd0},
    '{8'h80, 1'b1, 1'b0, 1'b0, u8sv_pkg::ST_OK,        16'd0},
    '{8'hED, 1'b0, 1'b0, 1'b0, u8sv_pkg::ST_OK,        16'd0},
    '{8'hA0, 1'b0, 1'b0, 1'b0, u8sv_pkg::ST_OK,        16'd0},
    '{8'h80, 1'b1, 1'b0, 1'b0, u8sv_pkg::ST_OK,        16'd0},
    '{8'hF4, 1'b0, 1'b0, 1'b0, u8sv_pkg::ST_OK,        16'd0},
    '{8'h90, 1'b0, 1'b0, 1'b0, u8sv_pkg::ST_OK,        16'd0},
    '{8'h80, 1'b0, 1'b0, 1'b0, u8sv_pkg::ST_OK,        16'd0},
    '{8'h80, 1'b1, 1'b0, 1'b0, u8sv_pkg::ST_OK,        16'd0},
    '{8'hF0, 1'b0, 1'b0, 1'b0, u8sv_pkg::ST_OK,        16'd0},
    '{8'h9F, 1'b0, 1'b0, 1'b0, u8sv_pkg::ST_OK,        16'd0},
    '{8'h98, 1'b1, 1'b0, 1'b1, u8sv_pkg::ST_MALFORMED, 16'd3},
    '{8'hE2, 1'b0, 1'b0, 1'b0, u8sv_pkg::ST_OK,        16'd0},
    '{8'h80, 1'b0, 1'b0, 1'b0, u8sv_pkg::ST_OK,        16'd0},
    '{8'h8B, 1'b1, 1'b0, 1'b0, u8sv_pkg::ST_OK,        16'd0},
    '{8'hC2, 1'b0, 1'b0, 1'b0, u8sv_pkg::ST_OK,        16'd0},
    '{8'h41, 1'b1, 1'b0, 1'b1, u8sv_pkg::ST_MALFORMED, 16'd2},
    '{8'h41, 1'b0, 1'b0, 1'b0, u8sv_pkg::ST_OK,        16'd0},
    '{8'h00, 1'b0, 1'b1, 1'b1, u8sv_pkg::ST_EMPTY,     16'd0}
  };

  localparam logic [20:0] Specials [20] = '{
    21'h00AD, 21'h061C, 21'h200B, 21'h200F, 21'h2028, 21'h2029, 21'h202A,
    21'h202E, 21'h2060, 21'h206F, 21'h3164, 21'hFEFF, 21'hFDD0, 21'hFDEF,
    21'hFFFE, 21'h1FFFF, 21'h10FFFE, 21'h0085, 21'h00A0, 21'h2030
  };

  localparam u8sv_pkg::kind_e PhaseKind [8] = '{
    u8sv_pkg::KIND_ARG, u8sv_pkg::KIND_CONFIG, u8sv_pkg::KIND_PATH, u8sv_pkg::KIND_URL,
    u8sv_pkg::KIND_DISPLAY, u8sv_pkg::KIND_IDENT, u8sv_pkg::KIND_TOKEN,
    u8sv_pkg::KIND_STRUCT
  };
  localparam logic [15:0] PhaseMaxLen [8] = '{
    16'hFFFF, 16'd0, 16'd12, 16'd4096, 16'd5, 16'd20, 16'd9, 16'hFFFF
  };
  localparam bit PhaseAllowEmpty [8] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [1:0]  cfg_index_i    = 2'd0;
  logic [15:0] cfg_data_i     = 16'd0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i    = 8'd0;
  logic        last_byte_i    = 1'b0;
  logic        empty_marker_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [3:0]  status_o;
  logic [15:0] length_o;

  // typed expectation that travels with the word on the input
  logic              row_typed  = 1'b0;
  u8sv_pkg::status_e row_status = u8sv_pkg::ST_OK;
  logic [15:0]       row_length = 16'd0;

  int send_idle_pct = 22;
  int recv_idle_pct = 84;
  int hold_req      = 0;
  int hold_ack      = 0;
  int hold_left     = 0;
  int cycle_count   = 0;
  int error_count   = 0;

  result_word_t status_q [$];

  // model of the decoder: configuration and running string state
  u8sv_pkg::kind_e   cur_kind;
  logic [15:0]       cur_max_len;
  logic              cur_allow_empty;
  logic [15:0]       str_count;
  logic [1:0]        str_pending;
  logic [20:0]       str_partial;
  logic [1:0]        str_seq_class;
  u8sv_pkg::status_e str_first_err;
  u8sv_pkg::status_e str_class_err;
  logic              str_at_start;

  utf8_string_validator_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .empty_marker_i (empty_marker_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .length_o       (length_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic u8sv_pkg::status_e screen_codepoint(input logic [20:0] cp);
    bit tab_ok;
    bit unsafe;
    tab_ok = (cur_kind == u8sv_pkg::KIND_CONFIG || cur_kind == u8sv_pkg::KIND_STRUCT) &&
             cp == 21'h09;
    unsafe = cp == 21'h00AD || cp == 21'h061C ||
             (cp >= 21'h200B && cp <= 21'h200F) ||
             cp == 21'h2028 || cp == 21'h2029 ||
             (cp >= 21'h202A && cp <= 21'h202E) ||
             (cp >= 21'h2060 && cp <= 21'h206F) ||
             cp == 21'h3164 || cp == 21'hFEFF ||
             (cp >= 21'hFDD0 && cp <= 21'hFDEF) ||
             cp[15:0] >= 16'hFFFE;
    if ((!tab_ok && cp < 21'h20) || cp == 21'h7F || (cp >= 21'h80 && cp < 21'hA0) || unsafe)
      return u8sv_pkg::ST_CONTROL;
    if (cur_kind >= u8sv_pkg::KIND_IDENT && cp > 21'h7F)
      return u8sv_pkg::ST_NON_ASCII;
    return u8sv_pkg::ST_OK;
  endfunction

  task automatic clear_string();
    str_count     = 16'd0;
    str_pending   = 2'd0;
    str_partial   = 21'd0;
    str_seq_class = 2'd0;
    str_first_err = u8sv_pkg::ST_OK;
    str_class_err = u8sv_pkg::ST_OK;
    str_at_start  = 1'b1;
  endtask

  task automatic predict_status(input logic [7:0] b, input logic last, input logic empty,
                                output bit has_result, output result_word_t res);
    u8sv_pkg::status_e err;
    logic [20:0]       lowest;
    bit                ok;
    has_result = 1'b0;
    res = '{u8sv_pkg::ST_OK, 16'd0};
    if (empty) begin
      has_result = 1'b1;
      res.status = cur_allow_empty ? u8sv_pkg::ST_OK : u8sv_pkg::ST_EMPTY;
      clear_string();
    end else begin
      if (str_count != 16'hFFFF) str_count++;
      // decoding stops at the first error; the count goes on
      if (str_first_err == u8sv_pkg::ST_OK) begin
        err = u8sv_pkg::ST_OK;
        if (str_pending == 2'd0) begin
          if (b < 8'h80) begin
            err = screen_codepoint({13'd0, b});
          end else if (b >= 8'hC2 && b <= 8'hDF) begin
            str_pending = 2'd1;
            str_partial = {16'd0, b[4:0]};
          end else if (b >= 8'hE0 && b <= 8'hEF) begin
            str_pending = 2'd2;
            str_partial = {17'd0, b[3:0]};
          end else if (b >= 8'hF0 && b <= 8'hF4) begin
            str_pending = 2'd3;
            str_partial = {18'd0, b[2:0]};
          end else begin
            err = u8sv_pkg::ST_MALFORMED;
          end
          if (str_pending != 2'd0) str_seq_class = str_pending;
        end else if (b[7:6] != 2'b10) begin
          err = u8sv_pkg::ST_MALFORMED;
        end else begin
          str_partial = {str_partial[14:0], b[5:0]};
          str_pending = str_pending - 2'd1;
          if (str_pending == 2'd0) begin
            lowest = (str_seq_class == 2'd1) ? 21'h80 :
                     (str_seq_class == 2'd2) ? 21'h800 : 21'h10000;
            if (str_partial < lowest || str_partial > 21'h10FFFF ||
                (str_partial >= 21'hD800 && str_partial <= 21'hDFFF))
              err = u8sv_pkg::ST_MALFORMED;
            else
              err = screen_codepoint(str_partial);
          end
        end
        if (err != u8sv_pkg::ST_OK) str_first_err = err;
      end
      // class checks look at raw bytes under the kind set now
      if (str_class_err == u8sv_pkg::ST_OK) begin
        case (cur_kind)
          u8sv_pkg::KIND_IDENT: begin
            if (!(is_alpha(b) || b == "_" || (!str_at_start && is_digit(b))))
              str_class_err = u8sv_pkg::ST_IDENT;
          end
          u8sv_pkg::KIND_TOKEN: begin
            if (!(is_alpha(b) || is_digit(b) || b == "_" || b == "-" || b == "." || b == "+"))
              str_class_err = u8sv_pkg::ST_TOKEN;
          end
          u8sv_pkg::KIND_STRUCT: begin
            ok = b == 8'h09 || is_alpha(b) || is_digit(b);
            case (b)
              "_", ".", ",", ":", "=", "+", "\\", "-", "/", "@", "%",
              "{", "}", "[", "]", "(", ")", " ": ok = 1'b1;
              default: ;
            endcase
            if (!ok) str_class_err = u8sv_pkg::ST_STRUCT;
          end
          default: ;
        endcase
      end
      str_at_start = 1'b0;
      if (last) begin
        has_result = 1'b1;
        res.length = str_count;
        if (str_count > cur_max_len)
          res.status = u8sv_pkg::ST_TOO_LONG;
        else if (str_first_err != u8sv_pkg::ST_OK)
          res.status = str_first_err;
        else if (str_pending != 2'd0)
          res.status = u8sv_pkg::ST_MALFORMED;
        else
          res.status = str_class_err;
        clear_string();
      end
    end
  endtask

  // receiver: random stall, or a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_left = HoldCycles;
      hold_ack  = hold_req;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_words
    bit           got;
    result_word_t predicted;
    result_word_t exp_word;
    result_word_t typed_word;
    cycle_count++;
    if (cycle_count > LimitCycles) begin
      $display("end of test: mismatches");
      $finish;
    end else if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (status_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected word: expected none, got status %0d length %0d",
                   $time, status_o, length_o);
        end else begin
          exp_word = status_q.pop_front();
          if (status_o !== exp_word.status) begin
            error_count++;
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, exp_word.status, status_o);
          end
          if (length_o !== exp_word.length) begin
            error_count++;
            $display("%0t: length mismatch: expected %0d, got %0d",
                     $time, exp_word.length, length_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        predict_status(data_byte_i, last_byte_i, empty_marker_i, got, predicted);
        if (got) begin
          typed_word = '{row_status, row_length};
          if (row_typed) status_q.insert(status_q.size(), typed_word);
          else status_q.insert(status_q.size(), predicted);
        end
      end
    end
  end

  task automatic send_word(input logic [7:0] data, input logic last, input logic empty,
                           input logic typed, input u8sv_pkg::status_e status,
                           input logic [15:0] length);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    data_byte_i    <= data;
    last_byte_i    <= last;
    empty_marker_i <= empty;
    row_typed      <= typed;
    row_status     <= status;
    row_length     <= length;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      u8sv_pkg::CFG_KIND:        cur_kind = u8sv_pkg::kind_e'(val[2:0]);
      u8sv_pkg::CFG_MAX_LEN:     cur_max_len = val;
      u8sv_pkg::CFG_ALLOW_EMPTY: cur_allow_empty = val[0];
      default: ;
    endcase
  endtask

  // drop valid, let every status word come out, then let the pipe settle
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic send_random_strings(input int n_words);
    logic [7:0]  str_bytes [$];
    logic [20:0] cp;
    string       ident_chars;
    string       pool;
    int          sent;
    int          nchars;
    int          nb;
    int          r;
    int          pick;
    ident_chars = "abcdefxyzABCQXZ_0123456789";
    case (cur_kind)
      u8sv_pkg::KIND_IDENT:  pool = ident_chars;
      u8sv_pkg::KIND_TOKEN:  pool = {ident_chars, "-.+"};
      u8sv_pkg::KIND_STRUCT: pool = {ident_chars, "-.+,:=\\/@%{}[]() \t"};
      default:               pool = {ident_chars, "-.+,:=\\/@%{}[]() \t!#$&*;<>?^|~"};
    endcase
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(99) < 5) begin
        send_word(8'($urandom), 1'($urandom), 1'b1, 1'b0, u8sv_pkg::ST_OK, 16'd0);
        sent++;
      end else begin
        str_bytes.delete();
        nchars = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 40);
        repeat (nchars) begin
          r = $urandom_range(99);
          if (r < 70) begin
            str_bytes.insert(str_bytes.size(), pool[$urandom_range(pool.len() - 1)]);
          end else if (r < 78) begin
            str_bytes.insert(str_bytes.size(), 8'($urandom_range(8'h7F)));
          end else if (r < 93) begin
            pick = $urandom_range(7);
            case (pick)
              0, 1:    cp = 21'($urandom_range('h80, 'h7FF));
              2:       cp = 21'($urandom_range('h800, 'hFFFF));
              3:       cp = 21'($urandom_range('h10000, 'h10FFFF));
              4:       cp = Specials[$urandom_range(19)];
              5:       cp = 21'($urandom_range('hD800, 'hDFFF));
              6:       cp = 21'($urandom_range('h110000, 'h1FFFFF));
              default: cp = 21'($urandom_range('h7F));
            endcase
            nb = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
            // stretch into an overlong form now and then, always for plain ASCII
            if ((pick == 7 || $urandom_range(7) == 0) && nb < 4) nb++;
            case (nb)
              1: str_bytes.insert(str_bytes.size(), {1'b0, cp[6:0]});
              2: begin
                str_bytes.insert(str_bytes.size(), {3'b110, cp[10:6]});
                str_bytes.insert(str_bytes.size(), {2'b10, cp[5:0]});
              end
              3: begin
                str_bytes.insert(str_bytes.size(), {4'b1110, cp[15:12]});
                str_bytes.insert(str_bytes.size(), {2'b10, cp[11:6]});
                str_bytes.insert(str_bytes.size(), {2'b10, cp[5:0]});
              end
              default: begin
                str_bytes.insert(str_bytes.size(), {5'b11110, cp[20:18]});
                str_bytes.insert(str_bytes.size(), {2'b10, cp[17:12]});
                str_bytes.insert(str_bytes.size(), {2'b10, cp[11:6]});
                str_bytes.insert(str_bytes.size(), {2'b10, cp[5:0]});
              end
            endcase
          end else begin
            str_bytes.insert(str_bytes.size(), 8'($urandom));
          end
        end
        // cut the tail off so the last sequence often ends early
        if (str_bytes.size() > 1 && $urandom_range(99) < 6)
          str_bytes.delete(str_bytes.size() - 1);
        foreach (str_bytes[i])
          send_word(str_bytes[i], i == str_bytes.size() - 1, 1'b0, 1'b0,
                    u8sv_pkg::ST_OK, 16'd0);
        sent += str_bytes.size();
      end
    end
  endtask

  initial begin
    cur_kind        = u8sv_pkg::KIND_ARG;
    cur_max_len     = u8sv_pkg::MaxLenReset;
    cur_allow_empty = 1'b0;
    clear_string();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < $size(DirectedRows); i++)
      send_word(DirectedRows[i].data, DirectedRows[i].last, DirectedRows[i].empty,
                DirectedRows[i].typed, DirectedRows[i].status, DirectedRows[i].length);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      if (p < 3) begin
        send_idle_pct = 22;
        recv_idle_pct = 84;
      end else if (p < 6) begin
        send_idle_pct = 84;
        recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(u8sv_pkg::CFG_KIND, {13'($urandom), 3'(PhaseKind[p])});
      write_reg(u8sv_pkg::CFG_MAX_LEN, PhaseMaxLen[p]);
      write_reg(u8sv_pkg::CFG_ALLOW_EMPTY, {15'($urandom), PhaseAllowEmpty[p]});
      if (p == 3) write_reg(CfgSpare, 16'($urandom));
      // hold the output back while the sender keeps pushing
      if (p == 6) hold_req++;
      send_random_strings(PhaseWords);
      // leave a partial string open across the next register change
      repeat (2)
        send_word(8'($urandom_range(8'h20, 8'h7E)), 1'b0, 1'b0, 1'b0,
                  u8sv_pkg::ST_OK, 16'd0);
      wait_idle();
    end

    if (error_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
